// ----- rtl/pru_pkg.sv -----
`timescale 1ns / 1ps
// Package for the PNG row unfilter: sizes, filter codes, register indexes
// and the item carried from the control stage to the reconstruction stage.
// No dependencies.
package pru_pkg;

  // Line store and left-neighbour sizes
  localparam int MAX_ROW_BYTES   = 16384;
  localparam int MAX_PIXEL_BYTES = 4;

  localparam int COL_W     = $clog2(MAX_ROW_BYTES);
  localparam int LEN_W     = $clog2(MAX_ROW_BYTES + 1);
  localparam int PB_W      = $clog2(MAX_PIXEL_BYTES + 1);
  localparam int PIX_IDX_W = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;

  // Field and register widths
  localparam int BYTE_W       = 8;
  localparam int ROW_PIX_W    = 13;
  localparam int PIX_BYTES_W  = 3;
  localparam int IMG_ROWS_W   = 16;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 16;
  localparam int FILT_W       = 3;
  localparam int PROD_W       = ROW_PIX_W + PIX_BYTES_W;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROW_PIXELS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_BYTES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_ROWS  = 2'd2;

  // Register reset values
  localparam logic [ROW_PIX_W-1:0]   ROW_PIXELS_RST  = 13'd1;
  localparam logic [PIX_BYTES_W-1:0] PIXEL_BYTES_RST = 3'd4;
  localparam logic [IMG_ROWS_W-1:0]  IMAGE_ROWS_RST  = 16'd1;

  // Filter type codes
  localparam logic [FILT_W-1:0] FILT_NONE  = 3'd0;
  localparam logic [FILT_W-1:0] FILT_SUB   = 3'd1;
  localparam logic [FILT_W-1:0] FILT_UP    = 3'd2;
  localparam logic [FILT_W-1:0] FILT_AVG   = 3'd3;
  localparam logic [FILT_W-1:0] FILT_PAETH = 3'd4;

  // Work item from the control stage to the reconstruction stage
  typedef struct packed {
    logic                 is_err;
    logic [BYTE_W-1:0]    data;
    logic [COL_W-1:0]     col;
    logic [FILT_W-1:0]    filter;
    logic                 use_left;
    logic                 top;
    logic [PIX_IDX_W-1:0] pb_sel;
    logic                 row_end;
    logic                 image_end;
  } item_t;

endpackage

// ----- rtl/png_row_unfilter_unit.sv -----
`timescale 1ns / 1ps
// PNG scanline unfilter: control stage, line store and reconstruction stage.
// Depends on rtl/pru_pkg.sv.
//
// A sample word waits in the stage 1 register, then in the output register.
// Throughput: one word per cycle while out_ready holds; the line store is read
// once per sample at accept and written back at reconstruction, one port each.
// Reset clears control state and registers; the line store is not cleared,
// the first row of each image reads its upper neighbours as zero instead.
module png_row_unfilter_unit (
  input  logic                            clk,
  input  logic                            rst,
  // input word channel
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [pru_pkg::BYTE_W-1:0]      in_byte,
  input  logic                            image_start,
  // output word channel
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [pru_pkg::BYTE_W-1:0]      out_byte,
  output logic                            row_end,
  output logic                            image_end,
  output logic                            bad_filter,
  // configuration writes
  input  logic                            cfg_we,
  input  logic [pru_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pru_pkg::CFG_DATA_W-1:0]  cfg_data
);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_FILTER,
    PH_SAMPLE
  } phase_t;

  // Configuration registers
  logic [pru_pkg::ROW_PIX_W-1:0]   row_pixels;
  logic [pru_pkg::PIX_BYTES_W-1:0] pixel_bytes;
  logic [pru_pkg::IMG_ROWS_W-1:0]  image_rows;

  // Control state
  phase_t                        phase;
  logic [pru_pkg::COL_W-1:0]     column_index;
  logic [pru_pkg::IMG_ROWS_W-1:0] row_index;
  logic [pru_pkg::FILT_W-1:0]    row_filter;
  logic                          top_row;

  // Pipeline
  logic                          p1_valid;
  pru_pkg::item_t                p1;
  pru_pkg::item_t                item;
  logic                          p1_adv;
  logic                          in_accept;
  logic                          emit;

  // Line store and neighbour shift registers
  logic [pru_pkg::BYTE_W-1:0]    line_mem [pru_pkg::MAX_ROW_BYTES];
  logic [pru_pkg::BYTE_W-1:0]    mem_rdata;
  logic                          mem_rd;
  logic [pru_pkg::BYTE_W-1:0]    left_samples [pru_pkg::MAX_PIXEL_BYTES];
  logic [pru_pkg::BYTE_W-1:0]    upper_left_samples [pru_pkg::MAX_PIXEL_BYTES];

  // Control-stage decode
  phase_t                        eff_phase;
  logic                          filt_bad;
  logic [pru_pkg::PB_W-1:0]      pb_eff;
  logic [pru_pkg::PROD_W-1:0]    row_prod;
  logic [pru_pkg::LEN_W-1:0]     len_eff;
  logic                          col_last;
  logic                          last_row;
  logic [pru_pkg::LEN_W-1:0]     col_inc;
  logic [pru_pkg::IMG_ROWS_W:0]  row_inc;

  // Reconstruction-stage values
  logic [pru_pkg::BYTE_W-1:0]    nb_a;
  logic [pru_pkg::BYTE_W-1:0]    nb_b;
  logic [pru_pkg::BYTE_W-1:0]    nb_c;
  logic [pru_pkg::BYTE_W:0]      avg_sum;
  logic [pru_pkg::BYTE_W+1:0]    pth_p;
  logic [pru_pkg::BYTE_W+1:0]    pth_pa;
  logic [pru_pkg::BYTE_W+1:0]    pth_pb;
  logic [pru_pkg::BYTE_W+1:0]    pth_pc;
  logic [pru_pkg::BYTE_W+1:0]    d_a;
  logic [pru_pkg::BYTE_W+1:0]    d_b;
  logic [pru_pkg::BYTE_W+1:0]    d_c;
  logic [pru_pkg::BYTE_W-1:0]    paeth_pred;
  logic [pru_pkg::BYTE_W-1:0]    pred;
  logic [pru_pkg::BYTE_W-1:0]    res;
  logic                          sample_adv;

  // Handshakes
  assign p1_adv    = !out_valid || out_ready;
  assign in_ready  = !p1_valid || p1_adv;
  assign in_accept = in_valid && in_ready;

  // Configuration register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      row_pixels  <= pru_pkg::ROW_PIXELS_RST;
      pixel_bytes <= pru_pkg::PIXEL_BYTES_RST;
      image_rows  <= pru_pkg::IMAGE_ROWS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        pru_pkg::REG_ROW_PIXELS:  row_pixels  <= cfg_data[pru_pkg::ROW_PIX_W-1:0];
        pru_pkg::REG_PIXEL_BYTES: pixel_bytes <= cfg_data[pru_pkg::PIX_BYTES_W-1:0];
        pru_pkg::REG_IMAGE_ROWS:  image_rows  <= cfg_data[pru_pkg::IMG_ROWS_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective pixel size and row length
  always_comb begin
    if (pixel_bytes == '0) begin
      pb_eff = pru_pkg::PB_W'(1);
    end else if ({1'b0, pixel_bytes} > (pru_pkg::PIX_BYTES_W+1)'(pru_pkg::MAX_PIXEL_BYTES)) begin
      pb_eff = pru_pkg::PB_W'(pru_pkg::MAX_PIXEL_BYTES);
    end else begin
      pb_eff = pru_pkg::PB_W'(pixel_bytes);
    end
    row_prod = pru_pkg::PROD_W'(row_pixels) * pru_pkg::PROD_W'(pb_eff);
    if (row_prod == '0) begin
      len_eff = pru_pkg::LEN_W'(1);
    end else if (row_prod > pru_pkg::PROD_W'(pru_pkg::MAX_ROW_BYTES)) begin
      len_eff = pru_pkg::LEN_W'(pru_pkg::MAX_ROW_BYTES);
    end else begin
      len_eff = pru_pkg::LEN_W'(row_prod);
    end
  end

  // Control-stage decode of the incoming word
  always_comb begin
    eff_phase = image_start ? PH_FILTER : phase;
    filt_bad  = in_byte > pru_pkg::BYTE_W'(pru_pkg::FILT_PAETH);
    col_inc   = pru_pkg::LEN_W'(column_index) + pru_pkg::LEN_W'(1);
    col_last  = col_inc >= len_eff;
    row_inc   = {1'b0, row_index} + (pru_pkg::IMG_ROWS_W+1)'(1);
    last_row  = row_inc >= {1'b0, image_rows};

    item.is_err    = (eff_phase == PH_FILTER);
    item.data      = in_byte;
    item.col       = column_index;
    item.filter    = row_filter;
    item.use_left  = pru_pkg::LEN_W'(column_index) >= pru_pkg::LEN_W'(pb_eff);
    item.top       = top_row;
    item.pb_sel    = pru_pkg::PIX_IDX_W'(pb_eff - pru_pkg::PB_W'(1));
    item.row_end   = (eff_phase == PH_SAMPLE) && col_last;
    item.image_end = (eff_phase == PH_FILTER) || (col_last && last_row);

    emit   = in_accept && (((eff_phase == PH_FILTER) && filt_bad) || (eff_phase == PH_SAMPLE));
    mem_rd = in_accept && (eff_phase == PH_SAMPLE);
  end

  // Control state machine: phase, row and column tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      column_index <= '0;
      row_index    <= '0;
      row_filter   <= pru_pkg::FILT_NONE;
      top_row      <= 1'b1;
    end else if (in_accept) begin
      if (image_start) begin
        row_index <= '0;
        top_row   <= 1'b1;
      end
      case (eff_phase)
        PH_FILTER: begin
          row_filter <= in_byte[pru_pkg::FILT_W-1:0];
          if (filt_bad) begin
            phase <= PH_IDLE;
          end else begin
            phase        <= PH_SAMPLE;
            column_index <= '0;
          end
        end
        PH_SAMPLE: begin
          if (col_last) begin
            column_index <= '0;
            top_row      <= 1'b0;
            if (last_row) begin
              phase <= PH_IDLE;
            end else begin
              phase     <= PH_FILTER;
              row_index <= row_inc[pru_pkg::IMG_ROWS_W-1:0];
            end
          end else begin
            column_index <= col_inc[pru_pkg::COL_W-1:0];
          end
        end
        default: ;
      endcase
    end
  end

  // Stage 1 register: item waiting on line store read data
  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else if (emit) begin
      p1_valid <= 1'b1;
    end else if (p1_adv) begin
      p1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      p1 <= item;
    end
  end

  // Line store: read at accept, written back when the sample leaves stage 1.
  // A column is rewritten well before the next row reads it: a filter word
  // always separates the rows.
  always_ff @(posedge clk) begin
    if (sample_adv) begin
      line_mem[p1.col] <= res;
    end
    if (mem_rd) begin
      mem_rdata <= line_mem[column_index];
    end
  end

  // Neighbours; samples from before this row are masked off
  always_comb begin
    nb_a = p1.use_left ? left_samples[p1.pb_sel] : '0;
    nb_b = p1.top ? '0 : mem_rdata;
    nb_c = (p1.use_left && !p1.top) ? upper_left_samples[p1.pb_sel] : '0;
  end

  // Paeth predictor, ties go left, then up, then upper left
  always_comb begin
    pth_p  = {2'b00, nb_a} + {2'b00, nb_b} - {2'b00, nb_c};
    d_a    = pth_p - {2'b00, nb_a};
    d_b    = pth_p - {2'b00, nb_b};
    d_c    = pth_p - {2'b00, nb_c};
    pth_pa = d_a[pru_pkg::BYTE_W+1] ? -d_a : d_a;
    pth_pb = d_b[pru_pkg::BYTE_W+1] ? -d_b : d_b;
    pth_pc = d_c[pru_pkg::BYTE_W+1] ? -d_c : d_c;
    if ((pth_pa <= pth_pb) && (pth_pa <= pth_pc)) begin
      paeth_pred = nb_a;
    end else if (pth_pb <= pth_pc) begin
      paeth_pred = nb_b;
    end else begin
      paeth_pred = nb_c;
    end
  end

  // Filter selection and reconstruction
  always_comb begin
    avg_sum = {1'b0, nb_a} + {1'b0, nb_b};
    case (p1.filter)
      pru_pkg::FILT_SUB:   pred = nb_a;
      pru_pkg::FILT_UP:    pred = nb_b;
      pru_pkg::FILT_AVG:   pred = avg_sum[pru_pkg::BYTE_W:1];
      pru_pkg::FILT_PAETH: pred = paeth_pred;
      default:             pred = '0;
    endcase
    res        = p1.data + pred;
    sample_adv = p1_valid && p1_adv && !p1.is_err;
  end

  // Left and upper-left shift registers
  always_ff @(posedge clk) begin
    if (sample_adv) begin
      for (int k = pru_pkg::MAX_PIXEL_BYTES - 1; k > 0; k--) begin
        left_samples[k]       <= left_samples[k-1];
        upper_left_samples[k] <= upper_left_samples[k-1];
      end
      left_samples[0]       <= res;
      upper_left_samples[0] <= nb_b;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (p1_valid && p1_adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (p1_valid && p1_adv) begin
      out_byte   <= p1.is_err ? '0 : res;
      row_end    <= p1.row_end;
      image_end  <= p1.image_end;
      bad_filter <= p1.is_err;
    end
  end

endmodule

// ----- tb/sv/png_row_unfilter_unit_test.sv -----
`timescale 1ns / 1ps
// Self-checking bench for png_row_unfilter_unit: a queued word driver, a
// clocked monitor and an in-bench scanline reconstruction predictor.
// Depends on rtl/pru_pkg.sv and rtl/png_row_unfilter_unit.sv.
module png_row_unfilter_unit_test;
  import pru_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int RANDOM_WORDS   = 1500;

  typedef enum logic [1:0] {PARSE_IDLE, PARSE_FILTER, PARSE_SAMPLE} parse_phase_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              start;
  } in_word_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              row_end;
    logic              image_end;
    logic              bad_filter;
  } recon_word_t;

  logic                  clk         = 1'b0;
  logic                  rst         = 1'b1;
  logic                  in_valid    = 1'b0;
  logic                  in_ready;
  logic [BYTE_W-1:0]     in_byte     = '0;
  logic                  image_start = 1'b0;
  logic                  out_valid;
  logic                  out_ready   = 1'b0;
  logic [BYTE_W-1:0]     out_byte;
  logic                  row_end;
  logic                  image_end;
  logic                  bad_filter;
  logic                  cfg_we      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index   = '0;
  logic [CFG_DATA_W-1:0] cfg_data    = '0;

  // Bench bookkeeping
  in_word_t    filtered_q[$];
  recon_word_t recon_q[$];
  int unsigned words_queued = 0;
  int unsigned words_taken  = 0;
  int unsigned noise_words  = 0;
  int unsigned mismatches   = 0;
  int unsigned quiet_cycles = 0;
  int unsigned send_gap     = 0;
  int unsigned ready_hold   = 0;
  logic        in_taken     = 1'b0;
  bit          no_gaps      = 1'b0;

  // Predictor state and its copy of the registers
  logic [BYTE_W-1:0]    prior_row [MAX_ROW_BYTES];
  logic [BYTE_W-1:0]    left_hist [MAX_PIXEL_BYTES];
  logic [BYTE_W-1:0]    ul_hist   [MAX_PIXEL_BYTES];
  int unsigned          col_pos;
  int unsigned          row_num;
  int unsigned          covered_len;
  logic [FILT_W-1:0]    cur_filter;
  parse_phase_t         parse_ph;
  bit                   top_row_m;
  logic [ROW_PIX_W-1:0]   rp_m;
  logic [PIX_BYTES_W-1:0] pb_m;
  logic [IMG_ROWS_W-1:0]  rows_m;

  png_row_unfilter_unit i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_byte     (in_byte),
    .image_start (image_start),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .row_end     (row_end),
    .image_end   (image_end),
    .bad_filter  (bad_filter),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic int unsigned eff_pixel_bytes(input logic [PIX_BYTES_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_PIXEL_BYTES) return MAX_PIXEL_BYTES;
    return 32'(v);
  endfunction

  function automatic int unsigned row_len_of(input logic [ROW_PIX_W-1:0] rp,
                                             input logic [PIX_BYTES_W-1:0] pbv);
    int unsigned n;
    n = 32'(rp) * eff_pixel_bytes(pbv);
    if (n == 0) n = 1;
    if (n > MAX_ROW_BYTES) n = MAX_ROW_BYTES;
    return n;
  endfunction

  // Paeth: closest of left, up, upper-left to left + up - upper-left; ties in that order
  function automatic logic [BYTE_W-1:0] paeth_pick(input logic [BYTE_W-1:0] a,
                                                   input logic [BYTE_W-1:0] b,
                                                   input logic [BYTE_W-1:0] c);
    int ia, ib, ic, p, da, db, dc;
    ia = int'(a);
    ib = int'(b);
    ic = int'(c);
    p  = ia + ib - ic;
    da = (p > ia) ? p - ia : ia - p;
    db = (p > ib) ? p - ib : ib - p;
    dc = (p > ic) ? p - ic : ic - p;
    if (da <= db && da <= dc) return a;
    if (db <= dc) return b;
    return c;
  endfunction

  task automatic unfilter_reset();
    rp_m        = ROW_PIXELS_RST;
    pb_m        = PIXEL_BYTES_RST;
    rows_m      = IMAGE_ROWS_RST;
    col_pos     = 0;
    row_num     = 0;
    covered_len = 0;
    cur_filter  = FILT_NONE;
    parse_ph    = PARSE_IDLE;
    top_row_m   = 1'b1;
    for (int k = 0; k < MAX_PIXEL_BYTES; k++) begin
      left_hist[k] = '0;
      ul_hist[k]   = '0;
    end
    recon_q.delete();
  endtask

  // One accepted input word; pushes the reconstructed word it yields, if any
  task automatic unfilter_word(input logic [BYTE_W-1:0] b, input logic start);
    int unsigned pbn, len, col;
    logic [BYTE_W-1:0] a, up, ul, pred, res;
    recon_word_t r;
    if (start) begin
      row_num     = 0;
      top_row_m   = 1'b1;
      covered_len = 0;
      parse_ph    = PARSE_FILTER;
    end
    if (parse_ph == PARSE_IDLE) return;

    // filter byte: opens a row or kills the image
    if (parse_ph == PARSE_FILTER) begin
      cur_filter = b[FILT_W-1:0];
      if (b > 8'(FILT_PAETH)) begin
        parse_ph = PARSE_IDLE;
        r = '{data: '0, row_end: 1'b0, image_end: 1'b1, bad_filter: 1'b1};
        recon_q.push_back(r);
      end else begin
        parse_ph = PARSE_SAMPLE;
        col_pos  = 0;
        for (int k = 0; k < MAX_PIXEL_BYTES; k++) begin
          left_hist[k] = '0;
          ul_hist[k]   = '0;
        end
      end
      return;
    end

    // sample byte
    pbn = eff_pixel_bytes(pb_m);
    len = row_len_of(rp_m, pb_m);
    col = (col_pos >= MAX_ROW_BYTES) ? MAX_ROW_BYTES - 1 : col_pos;
    a   = (col >= pbn) ? left_hist[PIX_IDX_W'(pbn-1)] : '0;
    up  = top_row_m ? '0 : prior_row[col[COL_W-1:0]];
    ul  = (col >= pbn && !top_row_m) ? ul_hist[PIX_IDX_W'(pbn-1)] : '0;
    case (cur_filter)
      FILT_SUB:   pred = a;
      FILT_UP:    pred = up;
      FILT_AVG:   pred = 8'((9'(a) + 9'(up)) >> 1);
      FILT_PAETH: pred = paeth_pick(a, up, ul);
      default:    pred = '0;
    endcase
    res = b + pred;

    for (int k = MAX_PIXEL_BYTES - 1; k > 0; k--) begin
      left_hist[k] = left_hist[k-1];
      ul_hist[k]   = ul_hist[k-1];
    end
    left_hist[0]   = res;
    ul_hist[0]     = up;
    prior_row[col[COL_W-1:0]] = res;

    r = '{data: res, row_end: 1'b0, image_end: 1'b0, bad_filter: 1'b0};
    if (col + 1 >= len) begin
      r.row_end = 1'b1;
      if (row_num + 1 >= 32'(rows_m)) begin
        r.image_end = 1'b1;
        parse_ph    = PARSE_IDLE;
      end else begin
        row_num  = (row_num + 1) & 16'hFFFF;
        parse_ph = PARSE_FILTER;
      end
      top_row_m = 1'b0;
      col_pos   = 0;
      if (len > covered_len) covered_len = len;
    end else begin
      col_pos = col + 1;
    end
    recon_q.push_back(r);
  endtask

  // ---------------------------------------------------------------------------
  // Driver, receiver and monitor
  // ---------------------------------------------------------------------------

  // mostly short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (no_gaps) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // input words: hold until taken, then an optional gap
  always @(negedge clk) begin : drive_words
    in_word_t w;
    if (!in_valid || in_taken) begin
      if (send_gap != 0) begin
        in_valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (filtered_q.size() != 0) begin
        w           = filtered_q.pop_front();
        in_valid    <= 1'b1;
        in_byte     <= w.data;
        image_start <= w.start;
        send_gap    <= pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // output side back-pressure
  always @(negedge clk) begin
    if (ready_hold != 0) begin
      out_ready  <= 1'b0;
      ready_hold <= ready_hold - 1;
    end else begin
      out_ready  <= 1'b1;
      ready_hold <= pick_gap();
    end
  end

  task automatic check_field(input string field, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s expected %0h, got %0h", $time, field, want, got);
    end
  endtask

  // compare outputs first, then predict from the word taken at this edge
  always @(posedge clk) begin : watch_words
    recon_word_t e;
    in_taken <= in_valid && in_ready && !rst;
    if (rst) begin
      unfilter_reset();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_ROW_PIXELS:  rp_m   = cfg_data[ROW_PIX_W-1:0];
          REG_PIXEL_BYTES: pb_m   = cfg_data[PIX_BYTES_W-1:0];
          REG_IMAGE_ROWS:  rows_m = cfg_data[IMG_ROWS_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (recon_q.size() == 0) begin
          mismatches++;
          $display("%0t: word with nothing expected, out_byte got %0h", $time, out_byte);
        end else begin
          e = recon_q.pop_front();
          check_field("out_byte", e.data, out_byte);
          check_field("row_end", {7'd0, e.row_end}, {7'd0, row_end});
          check_field("image_end", {7'd0, e.image_end}, {7'd0, image_end});
          check_field("bad_filter", {7'd0, e.bad_filter}, {7'd0, bad_filter});
        end
      end
      if (in_valid && in_ready) begin
        unfilter_word(in_byte, image_start);
        words_taken++;
      end
    end
  end

  // watchdog on cycles in which no word is accepted or delivered
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  task automatic push_word(input logic [BYTE_W-1:0] b, input logic start);
    in_word_t w;
    w = '{data: b, start: start};
    filtered_q.push_back(w);
    words_queued++;
  endtask

  function automatic logic [BYTE_W-1:0] rand_sample();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // all words taken and answered, then room for a filter byte still in flight
  task automatic wait_idle();
    do @(negedge clk);
    while (words_taken != words_queued || recon_q.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  // One image; a flawed one may carry a bad filter byte or stop short
  task automatic push_image(input int unsigned len, input int unsigned rows,
                            input bit flawed);
    int unsigned flaw, cut_row, cut_col;
    flaw    = flawed ? $urandom_range(0, 9) : 9;
    cut_row = $urandom_range(0, rows - 1);
    cut_col = $urandom_range(0, len - 1);
    for (int unsigned r = 0; r < rows; r++) begin
      if (flaw == 0 && r == cut_row) begin
        push_word(8'($urandom_range(5, 255)), r == 0);
        return;
      end
      push_word(8'($urandom_range(0, 4)), r == 0);
      for (int unsigned k = 0; k < len; k++) begin
        if (flaw == 1 && r == cut_row && k == cut_col) return;
        push_word(rand_sample(), 1'b0);
      end
    end
  endtask

  task automatic run_phase(input logic [ROW_PIX_W-1:0] rp,
                           input logic [PIX_BYTES_W-1:0] pbv,
                           input logic [IMG_ROWS_W-1:0] nrows,
                           input int unsigned images, input bit flawed);
    int unsigned len, rows, n;
    bit resume;
    len  = row_len_of(rp, pbv);
    rows = (nrows == 0) ? 1 : 32'(nrows);
    if (rows > 6) rows = 6;
    // the open image may go on under new settings only if every upper
    // neighbor it can still read has been written
    resume = parse_ph != PARSE_IDLE && len <= 64 && (top_row_m || len <= covered_len)
             && $urandom_range(0, 2) == 0;
    write_reg(REG_ROW_PIXELS, {3'($urandom_range(0, 7)), rp});
    write_reg(REG_PIXEL_BYTES, {13'($urandom), pbv});
    write_reg(REG_IMAGE_ROWS, nrows);
    no_gaps = ($urandom_range(0, 4) == 0);

    if (resume) begin
      // a column at or past the new length ends the row on the next sample
      if (parse_ph == PARSE_SAMPLE) begin
        n = (col_pos + 1 >= len) ? 1 : len - col_pos;
        repeat (n) push_word(rand_sample(), 1'b0);
      end
      repeat ($urandom_range(0, 2)) begin
        push_word(8'($urandom_range(0, 4)), 1'b0);
        repeat (len) push_word(rand_sample(), 1'b0);
      end
    end
    repeat (images) begin
      push_image(len, rows, flawed);
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 3)) begin
          push_word(8'($urandom), 1'b0);
          noise_words++;
        end
      end
    end
    wait_idle();
  endtask

  initial begin
    logic [ROW_PIX_W-1:0]   rp;
    logic [PIX_BYTES_W-1:0] pbv;
    logic [IMG_ROWS_W-1:0]  nrows;
    int unsigned            target;

    repeat (5) @(negedge clk);
    rst <= 1'b0;

    // Directed: reset settings give one row of four samples
    push_word(8'hFF, 1'b0);                      // idle, no start: dropped
    push_word(8'(FILT_NONE), 1'b1);
    push_word(8'h00, 1'b0);
    push_word(8'hFF, 1'b0);
    push_word(8'h80, 1'b0);
    push_word(8'h7F, 1'b0);
    wait_idle();

    // every filter over two-sample rows, one byte per pixel
    write_reg(REG_ROW_PIXELS, 16'd2);
    write_reg(REG_PIXEL_BYTES, 16'd1);
    write_reg(REG_IMAGE_ROWS, 16'd5);
    push_word(8'(FILT_NONE), 1'b1);
    push_word(8'hFF, 1'b0);
    push_word(8'h01, 1'b0);
    push_word(8'(FILT_SUB), 1'b0);
    push_word(8'hFF, 1'b0);
    push_word(8'hFF, 1'b0);
    push_word(8'(FILT_UP), 1'b0);
    push_word(8'h01, 1'b0);
    push_word(8'h02, 1'b0);
    push_word(8'(FILT_AVG), 1'b0);
    push_word(8'hFF, 1'b0);
    push_word(8'hFF, 1'b0);
    push_word(8'(FILT_PAETH), 1'b0);
    push_word(8'h03, 1'b0);
    push_word(8'h04, 1'b0);
    wait_idle();

    // unknown filters, with a dropped byte between
    push_word(8'h05, 1'b1);
    push_word(8'hFF, 1'b0);
    push_word(8'hFF, 1'b1);
    wait_idle();

    // Register extremes: zeros, oversized pixel, tall image
    run_phase(13'd0, 3'd0, 16'd0, 3, 1'b1);
    run_phase(13'd3, 3'd5, 16'd3, 2, 1'b1);
    run_phase(13'd1, 3'd1, 16'hFFFF, 2, 1'b1);

    // Oversized row clamps to the line store; only its head is sent
    write_reg(REG_ROW_PIXELS, 16'h1FFF);
    write_reg(REG_PIXEL_BYTES, 16'd7);
    write_reg(REG_IMAGE_ROWS, 16'd2);
    push_word(8'(FILT_PAETH), 1'b1);
    repeat (40) push_word(rand_sample(), 1'b0);
    wait_idle();

    run_phase(13'd2, 3'd6, 16'd4, 2, 1'b1);

    // Random settings and images
    target = words_queued - noise_words + RANDOM_WORDS;
    while (words_queued - noise_words < target) begin
      case ($urandom_range(0, 9))
        0:       rp = 13'd0;
        1, 2:    rp = 13'($urandom_range(7, 16));
        default: rp = 13'($urandom_range(1, 6));
      endcase
      pbv = 3'($urandom_range(0, 7));
      case ($urandom_range(0, 9))
        0:       nrows = 16'd0;
        1:       nrows = 16'hFFFF;
        2:       nrows = 16'($urandom_range(5, 12));
        default: nrows = 16'($urandom_range(1, 4));
      endcase
      run_phase(rp, pbv, nrows, $urandom_range(1, 3), 1'b1);
    end

    wait_idle();
    repeat (8) @(negedge clk);
    if (mismatches == 0 && recon_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
